### sv/lzte_pkg.sv
// Package for the LZ77 token encoder: payload types of the input and result channels.
// Depends on nothing; used by lz77_token_encoder.
package lzte_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } lzte_in_t;

    typedef struct packed {
        logic [12:0] distance;
        logic [3:0]  match_length;
        logic [7:0]  literal;
        logic        last;
    } lzte_out_t;

endpackage

### sv/lzte_dict_ram.sv
// Dictionary byte store: one write port and one read port with registered read data.
// Depends on nothing.
module lzte_dict_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/lz77_token_encoder.sv
// LZ77 token encoder top level: lookahead, failure links, sequencer and output register.
// Depends on lzte_pkg and lzte_dict_ram.
//
//  channel | signals                      | payload
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data  | lzte_in_t  (byte, end flag)
//  out     | out_valid, out_stall, out_data| lzte_out_t (distance, length,
//          |                              |   literal, last)
//
// A byte that does not fill the lookahead is simply stored there. A token first
// builds the failure links for each lookahead byte (one load, one final step and
// the fallback steps along the links), then scans each stored dictionary byte
// (one read of the dictionary RAM port and its registered data, plus fallback
// steps), then moves the matched bytes and the literal into the dictionary. At
// end of stream the block drains one token after another and then clears its
// pointers. in_stall is high whenever the sequencer is busy; a finished token
// waits in the output register while out_stall holds.
module lz77_token_encoder #(
    parameter int DICT_DEPTH      = 4096,
    parameter int LOOKAHEAD_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lzte_pkg::lzte_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lzte_pkg::lzte_out_t out_data
);

    localparam int AW    = $clog2(DICT_DEPTH);
    localparam int FW    = $clog2(DICT_DEPTH + 1);
    localparam int LW    = $clog2(LOOKAHEAD_DEPTH);
    localparam int CW    = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int KPW   = $clog2(LOOKAHEAD_DEPTH + 2);
    localparam int DISTW = $clog2(DICT_DEPTH + LOOKAHEAD_DEPTH + 1);

    localparam logic [AW-1:0]  LAST_ADDR = AW'(DICT_DEPTH - 1);
    localparam logic [FW-1:0]  DICT_FULL = FW'(DICT_DEPTH);
    localparam logic [CW-1:0]  LOOK_FULL = CW'(LOOKAHEAD_DEPTH);
    localparam logic [LW:0]    LOOK_MOD  = (LW+1)'(LOOKAHEAD_DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_DRAIN    = 10'b0000000010,
        ST_FB_LOAD  = 10'b0000000100,
        ST_FB_STEP  = 10'b0000001000,
        ST_SC_INIT  = 10'b0000010000,
        ST_SC_FETCH = 10'b0000100000,
        ST_SC_MATCH = 10'b0001000000,
        ST_CAP      = 10'b0010000000,
        ST_PUT      = 10'b0100000000,
        ST_HOLD     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Pointers and counters of the stream.
    logic [LW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic           drain_reg, drain_next;
    logic           term_reg, term_next;

    // Working registers of one token. Link values and scan states are kept
    // offset by one, so that the "no prefix" link reads as zero.
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  fp_reg, fp_next;
    logic [7:0]     cj_reg, cj_next;
    logic [KPW-1:0] kp_reg, kp_next;
    logic [FW-1:0]  t_reg, t_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [KPW-1:0] best_reg, best_next;
    logic [DISTW-1:0] dist_reg, dist_next;
    logic [KPW-1:0] pj_reg, pj_next;
    logic [7:0]     lit_reg, lit_next;

    logic                out_valid_reg, out_valid_next;
    lzte_pkg::lzte_out_t out_data_reg, out_data_next;

    logic [7:0]    look_mem [LOOKAHEAD_DEPTH];
    logic [CW-1:0] link_mem [1:LOOKAHEAD_DEPTH];

    logic          look_we;
    logic [LW-1:0] look_wi;
    logic [7:0]    look_wd;
    logic          link_we;
    logic [CW-1:0] link_wi;
    logic [CW-1:0] link_wd;

    logic [KPW-1:0] pat_idx;
    logic [7:0]     pat_val;
    logic [CW-1:0]  link_idx;
    logic [CW-1:0]  link_val;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    logic [DISTW+12:0] dist_ext;
    logic [KPW+3:0]    best_ext;

    function automatic logic [LW-1:0] look_slot(logic [LW-1:0] base, logic [KPW-1:0] off);
        logic [LW+KPW:0] sum;
        sum = (LW+KPW+1)'(base) + (LW+KPW+1)'(off);
        if (sum >= (LW+KPW+1)'(LOOKAHEAD_DEPTH))
        begin
            sum = sum - (LW+KPW+1)'(LOOKAHEAD_DEPTH);
        end
        return sum[LW-1:0];
    endfunction

    // Pattern byte i (1-based) is lookahead entry head + i - 1.
    assign pat_val  = look_mem[look_slot(head_reg, (pat_idx == '0) ? '0 : pat_idx - 1'b1)];
    assign link_val = (link_idx == '0) ? '0 : link_mem[link_idx];

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dist_ext = {13'd0, dist_reg};
    assign best_ext = {4'd0, best_reg};

    lzte_dict_ram #(
        .DEPTH (DICT_DEPTH),
        .AW    (AW)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (pat_val),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [LW:0]    hsum;
        logic [CW-1:0]  used;
        logic [CW-1:0]  remain;
        logic [KPW-1:0] cap;

        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        drain_next     = drain_reg;
        term_next      = term_reg;
        j_next         = j_reg;
        fp_next        = fp_reg;
        cj_next        = cj_reg;
        kp_next        = kp_reg;
        t_next         = t_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        dist_next      = dist_reg;
        pj_next        = pj_reg;
        lit_next       = lit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        look_we  = 1'b0;
        look_wi  = look_slot(head_reg, KPW'(count_reg));
        look_wd  = in_data.data_byte;
        link_we  = 1'b0;
        link_wi  = j_reg + 1'b1;
        link_wd  = fp_reg + 1'b1;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        pat_idx  = kp_reg;
        link_idx = (kp_reg == '0) ? '0 : CW'(kp_reg - 1'b1);

        hsum   = '0;
        used   = CW'(best_reg) + 1'b1;
        remain = count_reg - used;
        cap    = KPW'(count_reg) - 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    look_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                    j_next     = '0;
                    if (in_data.end_of_stream)
                    begin
                        drain_next = 1'b1;
                        term_next  = 1'b0;
                        state_next = ST_DRAIN;
                    end
                    else if (count_reg + 1'b1 == LOOK_FULL)
                    begin
                        state_next = ST_FB_LOAD;
                    end
                end
            end

            ST_DRAIN:
            begin
                j_next = '0;
                if (count_reg == '0 && term_reg)
                begin
                    head_next  = '0;
                    count_next = '0;
                    wp_next    = '0;
                    fill_next  = '0;
                    drain_next = 1'b0;
                    term_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // The terminal zero goes in as soon as the lookahead has room.
                    if (!term_reg && count_reg != LOOK_FULL)
                    begin
                        look_we    = 1'b1;
                        look_wd    = 8'd0;
                        count_next = count_reg + 1'b1;
                        term_next  = 1'b1;
                    end
                    state_next = ST_FB_LOAD;
                end
            end

            ST_FB_LOAD:
            begin
                link_idx   = j_reg;
                pat_idx    = KPW'(j_reg) + 1'b1;
                fp_next    = link_val;
                cj_next    = pat_val;
                state_next = ST_FB_STEP;
            end

            ST_FB_STEP:
            begin
                pat_idx  = KPW'(fp_reg);
                link_idx = (fp_reg == '0) ? '0 : fp_reg - 1'b1;
                if (fp_reg != '0 && pat_val != cj_reg)
                begin
                    fp_next = link_val;
                end
                else
                begin
                    link_we = 1'b1;
                    j_next  = j_reg + 1'b1;
                    if (j_reg + 1'b1 == count_reg)
                    begin
                        state_next = ST_SC_INIT;
                    end
                    else
                    begin
                        state_next = ST_FB_LOAD;
                    end
                end
            end

            ST_SC_INIT:
            begin
                kp_next   = KPW'(1);
                best_next = '0;
                dist_next = '0;
                t_next    = '0;
                if ((FW+1)'(wp_reg) >= (FW+1)'(fill_reg))
                begin
                    pos_next = AW'((FW+1)'(wp_reg) - (FW+1)'(fill_reg));
                end
                else
                begin
                    pos_next = AW'((FW+1)'(wp_reg) + (FW+1)'(DICT_DEPTH) - (FW+1)'(fill_reg));
                end
                if (fill_reg == '0)
                begin
                    state_next = ST_CAP;
                end
                else
                begin
                    state_next = ST_SC_FETCH;
                end
            end

            ST_SC_FETCH:
            begin
                ram_re     = 1'b1;
                pos_next   = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;
                state_next = ST_SC_MATCH;
            end

            ST_SC_MATCH:
            begin
                if (kp_reg == KPW'(count_reg) + 1'b1)
                begin
                    // Whole lookahead matched: fall back before the next byte.
                    kp_next = KPW'(link_val);
                end
                else if (kp_reg != '0 && pat_val != ram_rdata)
                begin
                    kp_next = KPW'(link_val);
                end
                else
                begin
                    if (kp_reg != '0 && kp_reg >= best_reg)
                    begin
                        best_next = kp_reg;
                        dist_next = DISTW'(fill_reg) - DISTW'(t_reg) + DISTW'(kp_reg)
                                    - 1'b1;
                    end
                    kp_next = kp_reg + 1'b1;
                    t_next  = t_reg + 1'b1;
                    if (t_reg + 1'b1 == fill_reg)
                    begin
                        state_next = ST_CAP;
                    end
                    else
                    begin
                        state_next = ST_SC_FETCH;
                    end
                end
            end

            ST_CAP:
            begin
                // A literal must always follow the match.
                if (best_reg > cap)
                begin
                    best_next = cap;
                    if (cap == '0)
                    begin
                        dist_next = '0;
                    end
                end
                pj_next    = KPW'(1);
                state_next = ST_PUT;
            end

            ST_PUT:
            begin
                pat_idx = pj_reg;
                ram_we  = 1'b1;
                wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                if (fill_reg != DICT_FULL)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if (pj_reg == best_reg + 1'b1)
                begin
                    lit_next   = pat_val;
                    state_next = ST_HOLD;
                end
                else
                begin
                    pj_next = pj_reg + 1'b1;
                end
            end

            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.distance      = dist_ext[12:0];
                    out_data_next.match_length  = best_ext[3:0];
                    out_data_next.literal       = lit_reg;
                    out_data_next.last          = drain_reg && term_reg && (remain == '0);
                    hsum = (LW+1)'(head_reg) + (LW+1)'(used);
                    if (hsum >= LOOK_MOD)
                    begin
                        hsum = hsum - LOOK_MOD;
                    end
                    head_next  = hsum[LW-1:0];
                    count_next = remain;
                    state_next = drain_reg ? ST_DRAIN : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        fp_reg       <= fp_next;
        cj_reg       <= cj_next;
        kp_reg       <= kp_next;
        t_reg        <= t_next;
        pos_reg      <= pos_next;
        best_reg     <= best_next;
        dist_reg     <= dist_next;
        pj_reg       <= pj_next;
        lit_reg      <= lit_next;
        out_data_reg <= out_data_next;
        if (look_we)
        begin
            look_mem[look_wi] <= look_wd;
        end
        if (link_we)
        begin
            link_mem[link_wi] <= link_wd;
        end
    end

endmodule
